// File: hw/rtl/rhsv_pkg.sv
// Shared widths and pipeline payload types for the RGB to HSV converter.
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int unsigned CH_W  = 8;   // input channel width
  localparam int unsigned HUE_W = 9;   // hue result width (0..360)
  localparam int unsigned NUM_W = 18;  // dividend width, covers 2*360*255+255
  localparam int unsigned DVS_W = 9;   // divisor width, covers 2*255
  localparam int unsigned QUO_W = 9;   // quotient bits resolved by the cell row
  localparam int unsigned NUM_CELLS = QUO_W;

  // One restoring-division lane: running remainder, divisor, partial quotient
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Everything one pixel carries down the cell row
  typedef struct packed {
    div_lane_t       sat;
    div_lane_t       hue;
    logic [CH_W-1:0] val;
  } cell_bus_t;

endpackage

// File: hw/rtl/rhsv_prep.sv
// Front end: max/min, delta, hue sector, and the dividends and divisors.
`timescale 1ns / 1ps

module rhsv_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [rhsv_pkg::CH_W-1:0] red,
  input  logic [rhsv_pkg::CH_W-1:0] green,
  input  logic [rhsv_pkg::CH_W-1:0] blue,
  output logic                    out_valid_r,
  output rhsv_pkg::cell_bus_t     out_bus_r
);
  import rhsv_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // stage 1 registers
  logic                   s1_valid_r;
  logic [CH_W-1:0]        s1_val_r;
  logic [CH_W-1:0]        s1_delta_r;
  sector_t                s1_sector_r;
  logic signed [CH_W:0]   s1_diff_r;

  logic [CH_W-1:0]        vmax_nxt;
  logic [CH_W-1:0]        vmin_nxt;
  sector_t                sector_nxt;
  logic signed [CH_W:0]   diff_nxt;

  // stage 2 terms
  logic signed [19:0]     base_term;
  logic signed [19:0]     diff_term;
  logic signed [19:0]     num;
  cell_bus_t              bus_nxt;

  // Find extremes and the sector, red first, then green, then blue
  always_comb begin
    vmax_nxt = red;
    vmin_nxt = red;
    if (green > vmax_nxt) vmax_nxt = green;
    if (blue  > vmax_nxt) vmax_nxt = blue;
    if (green < vmin_nxt) vmin_nxt = green;
    if (blue  < vmin_nxt) vmin_nxt = blue;

    priority if (red == vmax_nxt) begin
      sector_nxt = SEC_RED;
      diff_nxt   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == vmax_nxt) begin
      sector_nxt = SEC_GREEN;
      diff_nxt   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sector_nxt = SEC_BLUE;
      diff_nxt   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // Build the hue numerator, wrapping negative red-sector hues by 360
  always_comb begin
    diff_term = 20'(s1_diff_r) * 20'sd60;
    unique case (s1_sector_r)
      SEC_RED: begin
        if (s1_diff_r < 0) begin
          base_term = $signed({12'b0, s1_delta_r}) * 20'sd360;
        end else begin
          base_term = 20'sd0;
        end
      end
      SEC_GREEN: base_term = $signed({12'b0, s1_delta_r}) * 20'sd120;
      SEC_BLUE:  base_term = $signed({12'b0, s1_delta_r}) * 20'sd240;
      default:   base_term = 20'sd0;
    endcase
    num = base_term + diff_term;

    // Round half up: quotient of (2p + q) / (2q); force a safe divisor at zero
    bus_nxt.val     = s1_val_r;
    bus_nxt.hue.rem = {num[NUM_W-2:0], 1'b0} + NUM_W'(s1_delta_r);
    bus_nxt.hue.dvs = (s1_delta_r == '0) ? '1 : {s1_delta_r, 1'b0};
    bus_nxt.hue.quo = '0;
    bus_nxt.sat.rem = NUM_W'(s1_delta_r) * NUM_W'(510) + NUM_W'(s1_val_r);
    bus_nxt.sat.dvs = (s1_val_r == '0) ? '1 : {s1_val_r, 1'b0};
    bus_nxt.sat.quo = '0;
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_val_r    <= vmax_nxt;
      s1_delta_r  <= vmax_nxt - vmin_nxt;
      s1_sector_r <= sector_nxt;
      s1_diff_r   <= diff_nxt;
      out_bus_r   <= bus_nxt;
    end
  end

endmodule

// File: hw/rtl/rhsv_cell.sv
// One restoring-division cell: resolves one quotient bit for hue and saturation.
`timescale 1ns / 1ps

module rhsv_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rhsv_pkg::cell_bus_t in_bus,
  output logic                out_valid_r,
  output rhsv_pkg::cell_bus_t out_bus_r
);
  import rhsv_pkg::*;

  cell_bus_t bus_nxt;

  function automatic div_lane_t div_step(input div_lane_t lane);
    logic [NUM_W-1:0] dsh;
    div_lane_t        res;
    dsh = NUM_W'(lane.dvs) << SHIFT;
    res = lane;
    if (lane.rem >= dsh) begin
      res.rem        = lane.rem - dsh;
      res.quo[SHIFT] = 1'b1;
    end
    return res;
  endfunction

  // Subtract the shifted divisor where it fits
  always_comb begin
    bus_nxt     = in_bus;
    bus_nxt.sat = div_step(in_bus.sat);
    bus_nxt.hue = div_step(in_bus.hue);
  end

  // Hand on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bus_r <= bus_nxt;
    end
  end

endmodule

// File: hw/rtl/rgb_to_hsv_int8.sv
// Pipeline: 2 front-end stages, then nine division cells, one quotient bit each;
// they hold up to eleven pixels in flight; the last cell is the output register.
// Throughput: one pixel per cycle while no result is stalled. The whole pipe holds
// while a result waits and out_ready is low.
// Reset: synchronous, active low; clears all valid flags, payload is not reset.
`timescale 1ns / 1ps

module rgb_to_hsv_int8 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rhsv_pkg::CH_W-1:0]  in_red,
  input  logic [rhsv_pkg::CH_W-1:0]  in_green,
  input  logic [rhsv_pkg::CH_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhsv_pkg::HUE_W-1:0] out_hue,
  output logic [rhsv_pkg::CH_W-1:0]  out_sat,
  output logic [rhsv_pkg::CH_W-1:0]  out_val
);
  import rhsv_pkg::*;

  logic      adv;
  logic      valid_chain [NUM_CELLS+1];
  cell_bus_t bus_chain   [NUM_CELLS+1];

  // Move the pipe unless a finished result is stalled
  assign adv      = !valid_chain[NUM_CELLS] || out_ready;
  assign in_ready = adv;

  rhsv_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (in_valid),
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .out_valid_r (valid_chain[0]),
    .out_bus_r   (bus_chain[0])
  );

  // Cell k resolves quotient bit QUO_W-1-k
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rhsv_cell #(
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (adv),
      .in_valid    (valid_chain[k]),
      .in_bus      (bus_chain[k]),
      .out_valid_r (valid_chain[k+1]),
      .out_bus_r   (bus_chain[k+1])
    );
  end

  // Drive the result channel from the last cell
  assign out_valid = valid_chain[NUM_CELLS];
  assign out_hue   = bus_chain[NUM_CELLS].hue.quo;
  assign out_sat   = bus_chain[NUM_CELLS].sat.quo[CH_W-1:0];
  assign out_val   = bus_chain[NUM_CELLS].val;

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= HUE_W'(360)))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_val == '0) |-> (out_sat == '0 && out_hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sat == '0) |-> (out_hue == '0))
    else $error("grey pixel with nonzero hue");

  a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bus_chain[NUM_CELLS].sat.quo[QUO_W-1] == 1'b0))
    else $error("saturation quotient overflow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(bus_chain[NUM_CELLS])))
    else $error("stalled result changed");
`endif

endmodule
